// ===== rtl/sobel_pkg.sv =====
// sobel_pkg: shared types, register map and constants for the Sobel edge block.
// No dependencies; imported by every module under rtl/.
package sobel_pkg;

  localparam int PIX_W    = 32;   // raw pixel
  localparam int LUMA_W   = 8;    // intensity byte
  localparam int LUMA_LSB = 24;   // intensity sits in bits 31..24
  localparam int FW_W     = 11;   // frame_width register
  localparam int FH_W     = 12;   // frame_height register
  localparam int TH_W     = 8;    // edge_threshold register
  localparam int ROW_W    = 13;   // input row counter, runs up to height + 3
  localparam int SUM_W    = 10;   // one side of a Sobel sum, max 4 * 255
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;
  localparam int Q_DEPTH  = 4;    // front-to-back queue entries
  localparam int Q_AW     = 2;

  localparam logic [FW_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [FH_W-1:0] HEIGHT_RST = 12'd480;
  localparam logic [TH_W-1:0] THRESH_RST = 8'd0;

  localparam logic [PIX_W-1:0] EDGE_PIX    = 32'hFFFF_FFFF;
  localparam logic [PIX_W-1:0] NO_EDGE_PIX = 32'h0000_0000;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH    = 2'd0,
    REG_FRAME_HEIGHT   = 2'd1,
    REG_EDGE_THRESHOLD = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [FW_W-1:0] frame_width;
    logic [FH_W-1:0] frame_height;
    logic [TH_W-1:0] edge_threshold;
  } cfg_t;

  // per-request decisions made by the front end
  typedef struct packed {
    logic emit;    // this request releases a result
    logic border;  // result sits on the frame border
    logic last;    // result closes the frame
  } item_flags_t;

  localparam int FLAGS_W = $bits(item_flags_t);

  function automatic logic [LUMA_W-1:0] luma(input logic [PIX_W-1:0] p);
    return p[LUMA_LSB +: LUMA_W];
  endfunction

endpackage

// ===== rtl/sobel_queue.sv =====
// sobel_queue: small register FIFO between the front end and the back end.
// Uses sobel_pkg for depth constants.
module sobel_queue
  import sobel_pkg::*;
#(
  parameter int DATA_W = 48
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output logic              empty
);

  logic [DATA_W-1:0] entries_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]     count_r, count_nxt;

  assign full     = count_r == (Q_AW+1)'(Q_DEPTH);
  assign empty    = count_r == '0;
  assign pop_data = entries_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (Q_AW+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (Q_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      end
      count_r <= count_nxt;
    end
  end

endmodule

// ===== rtl/sobel_front.sv =====
// sobel_front: request intake, frame position counters, result scheduling.
// Rebuilds its counters after reset and register writes. Uses sobel_pkg.
module sobel_front
  import sobel_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cfg_t                           cfg,
  input  logic                           cfg_wr,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_command,
  input  logic [PIX_W-1:0]               in_pixel_in,
  input  logic                           q_full,
  output logic                           push,
  output logic [$clog2(MAX_WIDTH)-1:0]   push_col,
  output logic [PIX_W-1:0]               push_pixel,
  output item_flags_t                    push_flags
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int ICW = ROW_W + WW + 1;
  localparam int SW  = ICW + 1;
  localparam int DCW = $clog2(ICW);

  typedef enum logic [2:0] {
    ST_MUL = 3'b001,
    ST_DIV = 3'b010,
    ST_RUN = 3'b100
  } fstate_t;

  fstate_t          state_r, state_nxt;
  logic [CW-1:0]    icol_r, icol_nxt, ocol_r, ocol_nxt;
  logic [ROW_W-1:0] irow_r, irow_nxt, orow_r, orow_nxt;
  logic [ICW-1:0]   opos_r, opos_nxt, incnt_r, incnt_nxt, total_r, total_nxt;
  logic [ICW-1:0]   dq_r, dq_nxt;
  logic [WW-1:0]    drem_r, drem_nxt;
  logic [DCW-1:0]   dcnt_r, dcnt_nxt;

  logic [WW-1:0]    w_eff;
  logic [FH_W-1:0]  h_eff;
  logic [ROW_W-1:0] h_lim;

  // divider step
  logic [WW:0]      rem_sh;
  logic             div_ge;
  logic [WW-1:0]    div_rem;
  logic [ICW-1:0]   div_q;

  // request evaluation
  logic             accept, restart, in_frame, drop, col_wrap, ocol_wrap;
  logic             emit, border, last;
  logic [CW-1:0]    icol_e, ocol_e, icol_n;
  logic [ROW_W-1:0] irow_e, orow_e, irow_n;
  logic [ICW-1:0]   opos_e, incnt_e, incnt_n;
  logic [SW-1:0]    need;

  always_comb begin
    if (cfg.frame_width == '0) begin
      w_eff = WW'(1);
    end else if (32'(cfg.frame_width) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg.frame_width);
    end
    h_eff = (cfg.frame_height == '0) ? FH_W'(1) : cfg.frame_height;
    h_lim = ROW_W'(h_eff) + ROW_W'(2);
  end

  // restoring divide of the output position by the width, one bit a cycle
  always_comb begin
    rem_sh  = {drem_r, dq_r[ICW-1]};
    div_ge  = rem_sh >= {1'b0, w_eff};
    div_rem = div_ge ? WW'(rem_sh - {1'b0, w_eff}) : WW'(rem_sh);
    div_q   = {dq_r[ICW-2:0], div_ge};
  end

  assign in_ready = (state_r == ST_RUN) && !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    // counters that no longer fit the frame start over
    restart = (opos_r >= total_r) || (irow_r > h_lim) || (WW'(icol_r) >= w_eff);
    icol_e  = restart ? '0 : icol_r;
    irow_e  = restart ? '0 : irow_r;
    opos_e  = restart ? '0 : opos_r;
    orow_e  = restart ? '0 : orow_r;
    ocol_e  = restart ? '0 : ocol_r;
    incnt_e = restart ? '0 : incnt_r;

    in_frame = irow_e < ROW_W'(h_eff);
    drop     = in_frame && in_command;    // pad while frame still arriving

    col_wrap = (WW'(icol_e) + WW'(1)) == w_eff;
    icol_n   = col_wrap ? '0 : icol_e + CW'(1);
    irow_n   = col_wrap ? irow_e + ROW_W'(1) : irow_e;
    incnt_n  = incnt_e + ICW'(1);

    // result lags the input by one row plus one pixel
    need = SW'(opos_e) + SW'(w_eff) + SW'(2);
    emit = SW'(incnt_n) >= need;

    border = (orow_e == '0) || (orow_e == ROW_W'(h_eff) - ROW_W'(1)) ||
             (ocol_e == '0) || (WW'(ocol_e) == w_eff - WW'(1));
    last      = opos_e == total_r - ICW'(1);
    ocol_wrap = (WW'(ocol_e) + WW'(1)) == w_eff;
  end

  assign push              = accept && !drop;
  assign push_col          = icol_e;
  assign push_pixel        = in_frame ? in_pixel_in : '0;
  assign push_flags.emit   = emit;
  assign push_flags.border = border;
  assign push_flags.last   = last;

  always_comb begin
    state_nxt = state_r;
    icol_nxt  = icol_r;
    irow_nxt  = irow_r;
    opos_nxt  = opos_r;
    orow_nxt  = orow_r;
    ocol_nxt  = ocol_r;
    incnt_nxt = incnt_r;
    total_nxt = total_r;
    dq_nxt    = dq_r;
    drem_nxt  = drem_r;
    dcnt_nxt  = dcnt_r;
    unique case (state_r)
      ST_MUL: begin
        total_nxt = ICW'(w_eff) * ICW'(h_eff);
        incnt_nxt = ICW'(irow_r) * ICW'(w_eff) + ICW'(icol_r);
        dq_nxt    = opos_r;
        drem_nxt  = '0;
        dcnt_nxt  = DCW'(ICW - 1);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        dq_nxt   = div_q;
        drem_nxt = div_rem;
        dcnt_nxt = dcnt_r - DCW'(1);
        if (dcnt_r == '0) begin
          orow_nxt  = ROW_W'(div_q);
          ocol_nxt  = CW'(div_rem);
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (accept) begin
          icol_nxt  = icol_e;
          irow_nxt  = irow_e;
          opos_nxt  = opos_e;
          orow_nxt  = orow_e;
          ocol_nxt  = ocol_e;
          incnt_nxt = incnt_e;
          if (!drop) begin
            icol_nxt  = icol_n;
            irow_nxt  = irow_n;
            incnt_nxt = incnt_n;
            if (emit && last) begin
              icol_nxt  = '0;
              irow_nxt  = '0;
              opos_nxt  = '0;
              orow_nxt  = '0;
              ocol_nxt  = '0;
              incnt_nxt = '0;
            end else if (emit) begin
              opos_nxt = opos_e + ICW'(1);
              ocol_nxt = ocol_wrap ? '0 : ocol_e + CW'(1);
              orow_nxt = ocol_wrap ? orow_e + ROW_W'(1) : orow_e;
            end
          end
        end
      end
      default: state_nxt = ST_MUL;
    endcase
    if (cfg_wr) begin
      state_nxt = ST_MUL;
    end
  end

  always_ff @(posedge clk) begin
    dq_r    <= dq_nxt;
    drem_r  <= drem_nxt;
    total_r <= total_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_MUL;
      icol_r  <= '0;
      irow_r  <= '0;
      opos_r  <= '0;
      orow_r  <= '0;
      ocol_r  <= '0;
      incnt_r <= '0;
      dcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      icol_r  <= icol_nxt;
      irow_r  <= irow_nxt;
      opos_r  <= opos_nxt;
      orow_r  <= orow_nxt;
      ocol_r  <= ocol_nxt;
      incnt_r <= incnt_nxt;
      dcnt_r  <= dcnt_nxt;
    end
  end

endmodule

// ===== rtl/sobel_back.sv =====
// sobel_back: line buffers, 3x3 window, Sobel magnitude, threshold, result register.
// Drains sobel_queue; uses sobel_pkg.
module sobel_back
  import sobel_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cfg_t                          cfg,
  input  logic                          q_empty,
  input  logic [$clog2(MAX_WIDTH)-1:0]  q_col,
  input  logic [PIX_W-1:0]              q_pixel,
  input  item_flags_t                   q_flags,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [PIX_W-1:0]              out_pixel_out,
  output logic                          out_frame_end
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic [LUMA_W-1:0] upper_mem_r  [MAX_WIDTH];
  logic [PIX_W-1:0]  middle_mem_r [MAX_WIDTH];

  logic              adv, s1_go;

  // stage 1: line buffer read data
  logic              s1_v_r;
  logic [CW-1:0]     s1_col_r;
  logic [PIX_W-1:0]  s1_pix_r;
  item_flags_t       s1_flags_r;
  logic [LUMA_W-1:0] top_rd_r;
  logic [PIX_W-1:0]  mid_rd_r;
  logic              fwd_v_r;
  logic [LUMA_W-1:0] fwd_d_r;
  logic [LUMA_W-1:0] top_val;

  logic [LUMA_W-1:0] win_r [9];
  logic [PIX_W-1:0]  held_r;

  // stage 2: window settled
  logic              s2_v_r;
  item_flags_t       s2_flags_r;
  logic [PIX_W-1:0]  s2_held_r;
  logic [SUM_W-1:0]  gx_p, gx_n, gy_p, gy_n, abs_gx, abs_gy;

  // stage 3: magnitudes
  logic              s3_v_r;
  item_flags_t       s3_flags_r;
  logic [PIX_W-1:0]  s3_held_r;
  logic [SUM_W-1:0]  abs_gx_r, abs_gy_r;
  logic [SUM_W:0]    mag;
  logic [TH_W-1:0]   g_sat;
  logic              hit;

  logic              out_valid_r;
  logic [PIX_W-1:0]  out_pixel_r;
  logic              out_last_r;

  // whole back end moves together; stalls only on a held result
  assign adv   = !out_valid_r || out_ready;
  assign pop   = adv && !q_empty;
  assign s1_go = adv && s1_v_r;

  // write of the upper row at this column lands on the same edge as the read
  assign top_val = fwd_v_r ? fwd_d_r : top_rd_r;

  always_ff @(posedge clk) begin
    if (pop) begin
      mid_rd_r            <= middle_mem_r[q_col];
      middle_mem_r[q_col] <= q_pixel;
      top_rd_r            <= upper_mem_r[q_col];
    end
    if (s1_go) begin
      upper_mem_r[s1_col_r] <= luma(mid_rd_r);
    end
  end

  always_comb begin
    gx_p = SUM_W'(win_r[2]) + (SUM_W'(win_r[5]) << 1) + SUM_W'(win_r[8]);
    gx_n = SUM_W'(win_r[0]) + (SUM_W'(win_r[3]) << 1) + SUM_W'(win_r[6]);
    gy_p = SUM_W'(win_r[6]) + (SUM_W'(win_r[7]) << 1) + SUM_W'(win_r[8]);
    gy_n = SUM_W'(win_r[0]) + (SUM_W'(win_r[1]) << 1) + SUM_W'(win_r[2]);
    abs_gx = (gx_p >= gx_n) ? gx_p - gx_n : gx_n - gx_p;
    abs_gy = (gy_p >= gy_n) ? gy_p - gy_n : gy_n - gy_p;
  end

  // |gx| + |gy| clips at 255 before the threshold compare
  assign mag   = (SUM_W+1)'(abs_gx_r) + (SUM_W+1)'(abs_gy_r);
  assign g_sat = (mag > (SUM_W+1)'(255)) ? '1 : mag[TH_W-1:0];
  assign hit   = g_sat > cfg.edge_threshold;

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      if (pop) begin
        s1_col_r   <= q_col;
        s1_pix_r   <= q_pixel;
        s1_flags_r <= q_flags;
      end
      fwd_d_r    <= luma(mid_rd_r);
      s2_flags_r <= s1_flags_r;
      s2_held_r  <= held_r;
      abs_gx_r   <= abs_gx;
      abs_gy_r   <= abs_gy;
      s3_flags_r <= s2_flags_r;
      s3_held_r  <= s2_held_r;
      if (s3_v_r) begin
        out_pixel_r <= s3_flags_r.border ? s3_held_r : (hit ? EDGE_PIX : NO_EDGE_PIX);
        out_last_r  <= s3_flags_r.last;
      end
    end
  end

  // control and window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      fwd_v_r     <= 1'b0;
      held_r      <= '0;
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else if (adv) begin
      s1_v_r      <= pop;
      fwd_v_r     <= pop && s1_v_r && (s1_col_r == q_col);
      s2_v_r      <= s1_v_r && s1_flags_r.emit;
      s3_v_r      <= s2_v_r;
      out_valid_r <= s3_v_r;
      if (s1_v_r) begin
        win_r[0] <= win_r[1];
        win_r[1] <= win_r[2];
        win_r[2] <= top_val;
        win_r[3] <= win_r[4];
        win_r[4] <= win_r[5];
        win_r[5] <= luma(mid_rd_r);
        win_r[6] <= win_r[7];
        win_r[7] <= win_r[8];
        win_r[8] <= luma(s1_pix_r);
        held_r   <= mid_rd_r;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pixel_r;
  assign out_frame_end = out_last_r;

endmodule

// ===== rtl/sobel_edge_threshold.sv =====
// sobel_edge_threshold: top level of the streaming 3x3 Sobel edge detector.
// Holds the register file; instantiates sobel_front, sobel_queue, sobel_back.
//
//   channel  | handshake              | payload
//   ---------+------------------------+----------------------------------
//   input    | in_valid / in_ready    | in_command, in_pixel_in
//   result   | out_valid / out_ready  | out_pixel_out, out_frame_end
//   config   | psel/penable/pwrite    | paddr, pwdata, prdata (pready = 1)
//
// One request per clock sustained while in_ready is high; a result passes through
// the queue, the back end stages and the result register. After reset and after
// every register write the front end rebuilds its frame counters with a multiply
// step and a bit-serial divide of the output position, with in_ready low meanwhile.
// A held result stalls the back end; the four-entry queue keeps in_ready high
// until it fills. Reset is synchronous, active low.
module sobel_edge_threshold
  import sobel_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  // input stream
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_command,
  input  logic [PIX_W-1:0]   in_pixel_in,
  // result stream
  output logic               out_valid,
  input  logic               out_ready,
  output logic [PIX_W-1:0]   out_pixel_out,
  output logic               out_frame_end,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int QDATA_W = FLAGS_W + CW + PIX_W;

  cfg_t         cfg_r;
  reg_idx_t     reg_idx;
  logic         apb_wr, cfg_wr;

  logic               q_push, q_full, q_pop, q_empty;
  logic [QDATA_W-1:0] q_push_data, q_pop_data;
  logic [CW-1:0]      push_col, pop_col;
  logic [PIX_W-1:0]   push_pixel, pop_pixel;
  item_flags_t        push_flags, pop_flags;

  // ---------------------------------------------------------------------------
  // Register file: frame_width at 0x0, frame_height at 0x4, edge_threshold at
  // 0x8. Writes land on the access phase; zero wait states.
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign apb_wr  = psel && penable && pwrite;

  always_comb begin
    cfg_wr = 1'b0;
    unique case (reg_idx)
      REG_FRAME_WIDTH,
      REG_FRAME_HEIGHT,
      REG_EDGE_THRESHOLD: cfg_wr = apb_wr;
      default:            cfg_wr = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width    <= WIDTH_RST;
      cfg_r.frame_height   <= HEIGHT_RST;
      cfg_r.edge_threshold <= THRESH_RST;
    end else if (apb_wr) begin
      unique case (reg_idx)
        REG_FRAME_WIDTH:    cfg_r.frame_width    <= pwdata[FW_W-1:0];
        REG_FRAME_HEIGHT:   cfg_r.frame_height   <= pwdata[FH_W-1:0];
        REG_EDGE_THRESHOLD: cfg_r.edge_threshold <= pwdata[TH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FRAME_WIDTH:    prdata = PDATA_W'(cfg_r.frame_width);
      REG_FRAME_HEIGHT:   prdata = PDATA_W'(cfg_r.frame_height);
      REG_EDGE_THRESHOLD: prdata = PDATA_W'(cfg_r.edge_threshold);
      default:            prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Front end: tracks input/output positions, drops early pads, decides for
  // each request whether a result comes out, is a border pixel, ends a frame.
  // ---------------------------------------------------------------------------
  sobel_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .cfg_wr      (cfg_wr),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_command  (in_command),
    .in_pixel_in (in_pixel_in),
    .q_full      (q_full),
    .push        (q_push),
    .push_col    (push_col),
    .push_pixel  (push_pixel),
    .push_flags  (push_flags)
  );

  assign q_push_data = {push_flags, push_col, push_pixel};
  assign {pop_flags, pop_col, pop_pixel} = q_pop_data;

  // Decouples intake from the line buffer pipeline.
  sobel_queue #(
    .DATA_W (QDATA_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  // ---------------------------------------------------------------------------
  // Back end: two line buffers, 3x3 window, |gx| + |gy|, threshold, output reg.
  // ---------------------------------------------------------------------------
  sobel_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .q_empty       (q_empty),
    .q_col         (pop_col),
    .q_pixel       (pop_pixel),
    .q_flags       (pop_flags),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel_out (out_pixel_out),
    .out_frame_end (out_frame_end)
  );

endmodule

// ===== dv/tb.sv =====
// tb: self-checking bench for sobel_edge_threshold (3x3 Sobel, threshold, border pass).
// Depends on rtl/sobel_pkg.sv and rtl/sobel_edge_threshold.sv; no files, no arguments.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sobel_pkg::*;

  localparam int MAX_W        = 1024;
  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 7;
  // Requests that produce no result may still be in the pipe when the last
  // expected result shows up.
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 200;   // long back-pressure stretch
  localparam int STALL_LIMIT   = 5000;  // cycles with no handshake at all
  localparam int RANDOM_ITEMS  = 350;
  localparam int MIN_RANDOM_FRAMES = 6;
  localparam int WIDE_ITEMS    = MAX_W + 16;  // first results of a full-width row
  localparam int TALL_ITEMS    = 30;
  localparam int MAX_REPORTS   = 10;

  // command field codes
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_PAD   = 1'b1;

  typedef struct {
    logic [PIX_W-1:0] pixel;
    logic             frame_end;
  } sobel_result_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_command;
  logic [PIX_W-1:0]   in_pixel_in;
  logic               out_valid;
  logic               out_ready;
  logic [PIX_W-1:0]   out_pixel_out;
  logic               out_frame_end;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  always #(CLK_PERIOD / 2) clk = ~clk;

  sobel_edge_threshold #(
    .MAX_WIDTH(MAX_W)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_pixel_in  (in_pixel_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_pixel_out(out_pixel_out),
    .out_frame_end(out_frame_end),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // ---------------------------------------------------------------------------
  // Bench-side copy of the detector: register shadows, line buffers, window
  // and frame counters. Every accepted request goes through sobel_predict,
  // which queues the result that request releases, if any.
  // ---------------------------------------------------------------------------
  logic [FW_W-1:0]   cfg_width;
  logic [FH_W-1:0]   cfg_height;
  logic [TH_W-1:0]   cfg_thresh;

  logic [LUMA_W-1:0] upper_luma [MAX_W];
  logic [PIX_W-1:0]  middle_pix [MAX_W];
  logic [LUMA_W-1:0] win [9];          // row major, column 2 is the newest
  int unsigned       in_col;
  int unsigned       in_row;
  int unsigned       out_pos;
  logic [PIX_W-1:0]  held_pix;         // line buffer pixel read one request ago

  sobel_result_t     pending_pixels[$];
  int unsigned       frames_closed;
  int unsigned       pixels_used;      // requests that were not ignored
  int unsigned       mismatches;
  bit                no_gaps;          // suppresses random idling on both sides
  bit                hold_results;     // asks the sink for one long hold-off
  sobel_result_t     want;

  function automatic void restart_counters();
    in_col  = 0;
    in_row  = 0;
    out_pos = 0;
  endfunction

  function automatic void reset_model();
    cfg_width  = WIDTH_RST;
    cfg_height = HEIGHT_RST;
    cfg_thresh = THRESH_RST;
    foreach (upper_luma[i]) upper_luma[i] = '0;
    foreach (middle_pix[i]) middle_pix[i] = '0;
    foreach (win[i]) win[i] = '0;
    held_pix = '0;
    restart_counters();
  endfunction

  // width 0 behaves as 1, anything past the line buffers as their full size
  function automatic int unsigned eff_width();
    int unsigned w;
    w = (cfg_width == 0) ? 1 : cfg_width;
    return (w > MAX_W) ? MAX_W : w;
  endfunction

  function automatic int unsigned eff_height();
    return (cfg_height == 0) ? 1 : cfg_height;
  endfunction

  // Counters that no longer fit the frame (after a resize) start a new frame.
  function automatic bit counters_stale(input int unsigned w, input int unsigned h);
    return out_pos >= w * h || in_row > h + 2 || in_col >= w;
  endfunction

  // True while a pixel request would be taken as frame data rather than a pad.
  function automatic bit frame_wants_pixels();
    if (counters_stale(eff_width(), eff_height())) return 1'b1;
    return in_row < eff_height();
  endfunction

  function automatic void sobel_predict(input logic cmd, input logic [PIX_W-1:0] pix);
    int unsigned       w, h, col, fill, orow, ocol;
    logic [PIX_W-1:0]  p, mid, res;
    logic [LUMA_W-1:0] top;
    int                k [9];
    int                gx, gy, g;
    logic              last;
    w = eff_width();
    h = eff_height();
    if (counters_stale(w, h)) restart_counters();

    // while the frame arrives a pad is dropped; past it, everything is a zero pad
    if (in_row < h) begin
      if (cmd == CMD_PAD) return;
      p = pix;
    end else begin
      p = '0;
    end
    pixels_used++;

    col = in_col;
    top = upper_luma[col];
    mid = middle_pix[col];
    for (int r = 0; r < 3; r++) begin
      win[3*r]   = win[3*r+1];
      win[3*r+1] = win[3*r+2];
    end
    win[2] = top;
    win[5] = mid[LUMA_LSB +: LUMA_W];
    win[8] = p[LUMA_LSB +: LUMA_W];
    upper_luma[col] = mid[LUMA_LSB +: LUMA_W];
    middle_pix[col] = p;

    res      = held_pix;
    held_pix = mid;

    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end

    // a result trails its input by one row plus one pixel
    fill = in_row * w + in_col;
    if (fill < out_pos + w + 2) return;

    orow = out_pos / w;
    ocol = out_pos % w;
    if (!(orow == 0 || orow == h - 1 || ocol == 0 || ocol == w - 1)) begin
      foreach (win[i]) k[i] = int'(win[i]);
      gx = (k[2] + 2 * k[5] + k[8]) - (k[0] + 2 * k[3] + k[6]);
      gy = (k[6] + 2 * k[7] + k[8]) - (k[0] + 2 * k[1] + k[2]);
      g  = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
      if (g > 255) g = 255;
      res = (g > int'(cfg_thresh)) ? EDGE_PIX : NO_EDGE_PIX;
    end

    last = (out_pos == w * h - 1);
    if (last) begin
      restart_counters();
      frames_closed++;
    end else begin
      out_pos++;
    end
    pending_pixels.push_back('{pixel: res, frame_end: last});
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] exp_v,
                                 input logic [63:0] got_v);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t ns: mismatch on %s: expected %h, got %h", $realtime, what, exp_v, got_v);
  endtask

  // ---------------------------------------------------------------------------
  // Drivers. Every test-level task starts and ends right after a falling edge.
  // ---------------------------------------------------------------------------

  // One request on the input channel; the prediction runs at the accepting edge.
  task automatic send_req(input logic cmd, input logic [PIX_W-1:0] pix);
    while (!no_gaps && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_command  <= cmd;
    in_pixel_in <= pix;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sobel_predict(cmd, pix);
    @(negedge clk);
  endtask

  // APB write, then read back; pready is tied high but still honored.
  task automatic write_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
    logic [PDATA_W-1:0] stored;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_FRAME_WIDTH:  cfg_width  = value[FW_W-1:0];
      REG_FRAME_HEIGHT: cfg_height = value[FH_W-1:0];
      default:          cfg_thresh = value[TH_W-1:0];
    endcase
    stored = (idx == REG_FRAME_WIDTH)  ? PDATA_W'(cfg_width) :
             (idx == REG_FRAME_HEIGHT) ? PDATA_W'(cfg_height) : PDATA_W'(cfg_thresh);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== stored) report_mismatch(idx.name(), stored, prdata);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Quiet the input and wait until every predicted result has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_frame(input int unsigned w, input int unsigned h, input int unsigned th);
    wait_drained();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_EDGE_THRESHOLD, th);
  endtask

  function automatic logic [PIX_W-1:0] rand_pixel();
    logic [PIX_W-1:0] px;
    px = $urandom;
    // dark, bright or anything: flat runs and hard steps both show up
    case ($urandom_range(2))
      0:       px[LUMA_LSB +: LUMA_W] = '0;
      1:       px[LUMA_LSB +: LUMA_W] = '1;
      default: ;
    endcase
    return px;
  endfunction

  // Feed the current frame and flush it with pads; stop early after
  // stop_after requests to leave a frame half done.
  task automatic run_frame(input int unsigned stop_after);
    int unsigned closed_at, n;
    closed_at = frames_closed;
    n = 0;
    while (frames_closed == closed_at && n < stop_after) begin
      if (frame_wants_pixels()) begin
        if ($urandom_range(99) < 5) send_req(CMD_PAD, $urandom);   // dropped
        send_req(CMD_PIXEL, rand_pixel());
      end else begin
        // pixel requests during the flush are taken as pads
        send_req(($urandom_range(99) < 10) ? CMD_PIXEL : CMD_PAD, $urandom);
      end
      n++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // 3x3 frame: eight border pixels pass through with all 32 bits, the center
  // sees a saturated gradient against threshold 254. A pad mid-frame is
  // dropped, a pixel after the frame acts as a pad.
  task automatic test_directed_frame();
    logic [PIX_W-1:0] frame_px [9];
    int unsigned      closed_at;
    frame_px = '{32'h0012_3456, 32'h80AB_CDEF, 32'hFF00_0001,
                 32'h00FF_FFFF, 32'h7F00_FF00, 32'hFFFF_00FF,
                 32'h0100_0000, 32'h0000_0000, 32'hFFFF_FFFF};
    set_frame(3, 3, 254);
    for (int i = 0; i < 9; i++) begin
      if (i == 4) send_req(CMD_PAD, 32'hFFFF_FFFF);
      send_req(CMD_PIXEL, frame_px[i]);
    end
    closed_at = frames_closed;
    send_req(CMD_PIXEL, 32'hDEAD_BEEF);
    while (frames_closed == closed_at) send_req(CMD_PAD, '0);
  endtask

  // Half a 3x3 frame, then the width shrinks to 1: the counters no longer
  // fit and a fresh 1x3 frame follows.
  task automatic test_mid_frame_resize();
    int unsigned closed_at;
    set_frame(3, 3, 0);
    for (int i = 0; i < 4; i++) send_req(CMD_PIXEL, i[0] ? 32'hFFFF_FFFF : 32'h0);
    wait_drained();
    write_reg(REG_FRAME_WIDTH, 1);
    closed_at = frames_closed;
    for (int i = 0; i < 3; i++) send_req(CMD_PIXEL, rand_pixel());
    while (frames_closed == closed_at) send_req(CMD_PAD, '0);
  endtask

  // Mostly small frames with random shapes and thresholds, some cut short.
  // One frame runs under a long sink hold-off; a run of frames has no idling.
  task automatic test_random_frames();
    int unsigned phase, w, h, th, stop_after, start_used;
    phase = 0;
    start_used = pixels_used;
    while (phase < MIN_RANDOM_FRAMES || pixels_used - start_used < RANDOM_ITEMS) begin
      no_gaps = (phase >= 4 && phase < 6);
      case ($urandom_range(19))
        0:       w = 0;
        1, 2, 3: w = $urandom_range(1, 3);
        4, 5:    w = $urandom_range(17, 64);
        default: w = $urandom_range(3, 16);
      endcase
      h  = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 8);
      th = $urandom_range(4);
      th = (th == 0) ? 0 : (th == 1) ? 255 : $urandom_range(255);
      if (phase == 3) begin
        // the sink stops for a long while as this frame streams in,
        // so the queue between front and back end fills and the input stalls
        set_frame(16, 4, $urandom_range(255));
        hold_results = 1'b1;
        run_frame('1);
      end else begin
        set_frame(w, h, th);
        stop_after = ($urandom_range(9) == 0) ? $urandom_range(1, 20) : '1;
        run_frame(stop_after);
      end
      phase++;
    end
    no_gaps = 1'b0;
  endtask

  // Width above the line buffer size, clamped to full width and cut short once
  // the first results of that row are out; tallest height at width 1, also cut
  // short; then zero width and height.
  task automatic test_size_extremes();
    set_frame(2047, 1, 255);
    run_frame(WIDE_ITEMS);
    set_frame(1, 4095, 0);
    run_frame(TALL_ITEMS);
    set_frame(0, 0, 0);
    run_frame('1);
  endtask

  // ---------------------------------------------------------------------------
  // Result sink: random ready, plus one long hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned held;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_results) begin
        out_ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(negedge clk);
        hold_results = 1'b0;
      end
      out_ready <= rst_n && (no_gaps || $urandom_range(99) >= 8);
    end
  end

  // Each result is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("result with no request pending", '0, out_pixel_out);
      end else begin
        want = pending_pixels.pop_front();
        if (out_pixel_out !== want.pixel)
          report_mismatch("pixel_out", want.pixel, out_pixel_out);
        if (out_frame_end !== want.frame_end)
          report_mismatch("frame_end", want.frame_end, out_frame_end);
      end
    end
  end

  // Watchdog: ends the run when no handshake of any kind happens for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    in_valid      = 1'b0;
    in_command    = CMD_PIXEL;
    in_pixel_in   = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    no_gaps       = 1'b0;
    hold_results  = 1'b0;
    frames_closed = 0;
    pixels_used   = 0;
    mismatches    = 0;
    rst_n         = 1'b0;
    reset_model();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_frame();
    test_mid_frame_resize();
    test_random_frames();
    test_size_extremes();
    wait_drained();

    if (mismatches == 0 && pending_pixels.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== sobel_edge_threshold.f =====
rtl/sobel_pkg.sv
rtl/sobel_queue.sv
rtl/sobel_front.sv
rtl/sobel_back.sv
rtl/sobel_edge_threshold.sv
dv/tb.sv
